// ===== rtl/core/sitrd_pkg.sv =====
// Shared types, constants and helpers for the signed integer to radix digits block.
// Used by every module under rtl/core; depends on nothing else.
package sitrd_pkg;

   // Fixed field widths.
   localparam int VALUE_W     = 32;
   localparam int RADIX_W     = 5;
   localparam int SYM_W       = 8;
   localparam int NUM_SYMS    = 16;
   localparam int SYMBOLS_W   = NUM_SYMS * SYM_W;
   localparam int DIGIT_IDX_W = 4;

   // Register port.
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Reserved symbol bytes.
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_RADIX  = 16;
   localparam int DEF_VALUE_BITS = 32;

   // Dividend bits retired per divider cycle, and depth of the item queue.
   localparam int STEP_BITS   = 8;
   localparam int QUEUE_DEPTH = 2;

   // Configuration as seen by the front and back ends.
   typedef struct packed {
      logic [RADIX_W-1:0]   radix;
      logic [SYMBOLS_W-1:0] symbols;
   } cfg_type;

   // Symbol byte for one digit value.
   function automatic logic [SYM_W-1:0] symbol_of(input logic [SYMBOLS_W-1:0] symbols,
                                                  input logic [DIGIT_IDX_W-1:0] digit);
      return symbols[digit*SYM_W +: SYM_W];
   endfunction

endpackage

// ===== rtl/core/sitrd_front.sv =====
// Front end: takes input transfers, checks the alphabet and forms sign and magnitude.
// Depends on sitrd_pkg.
module sitrd_front #(
   parameter int MAX_RADIX  = sitrd_pkg::DEF_MAX_RADIX,
   parameter int VALUE_BITS = sitrd_pkg::DEF_VALUE_BITS
) (
   input  sitrd_pkg::cfg_type               cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sitrd_pkg::VALUE_W-1:0]    req_value,
   output logic                             push_valid,
   input  logic                             push_ready,
   output logic [VALUE_BITS:0]              push_data
);
   import sitrd_pkg::*;

   logic                  alphabet_ok;
   logic                  bad_symbol;
   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic                  neg;

   // The alphabet is bad if its first radix symbols hold a sign byte or a repeated byte.
   always_comb begin
      bad_symbol = 1'b0;
      for (int i = 0; i < NUM_SYMS; i++) begin
         if (RADIX_W'(i) < cfg.radix) begin
            if (symbol_of(cfg.symbols, DIGIT_IDX_W'(i)) == SYM_PLUS ||
                symbol_of(cfg.symbols, DIGIT_IDX_W'(i)) == SYM_MINUS) begin
               bad_symbol = 1'b1;
            end
            for (int j = i + 1; j < NUM_SYMS; j++) begin
               if (RADIX_W'(j) < cfg.radix &&
                   symbol_of(cfg.symbols, DIGIT_IDX_W'(i)) ==
                   symbol_of(cfg.symbols, DIGIT_IDX_W'(j))) begin
                  bad_symbol = 1'b1;
               end
            end
         end
      end
   end

   assign alphabet_ok = (cfg.radix >= RADIX_W'(2)) &&
                        (cfg.radix <= RADIX_W'(MAX_RADIX)) && !bad_symbol;

   // Sign and magnitude; the most negative value wraps to 2^(VALUE_BITS-1) unsigned.
   assign raw = req_value[VALUE_BITS-1:0];
   assign neg = raw[VALUE_BITS-1];
   assign mag = neg ? (~raw + VALUE_BITS'(1)) : raw;

   // Every transfer is taken when the queue has room; a bad alphabet drops the item.
   assign req_ready  = push_ready;
   assign push_valid = req_valid && alphabet_ok;
   assign push_data  = {neg, mag};

endmodule

// ===== rtl/core/sitrd_queue.sv =====
// Short item queue between the front and back ends.
// Depends on sitrd_pkg only for its default depth; generic in width and depth.
module sitrd_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = sitrd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/sitrd_back.sv =====
// Back end: divides the magnitude by the radix digit by digit, then emits the text.
// Depends on sitrd_pkg; holds the digit buffer memory.
module sitrd_back #(
   parameter int MAX_RADIX  = sitrd_pkg::DEF_MAX_RADIX,
   parameter int VALUE_BITS = sitrd_pkg::DEF_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sitrd_pkg::cfg_type            cfg,
   input  logic                          q_valid,
   input  logic [VALUE_BITS:0]           q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sitrd_pkg::SYM_W-1:0]   rsp_symbol,
   output logic                          rsp_last
);
   import sitrd_pkg::*;

   localparam int DIGIT_W    = $clog2(MAX_RADIX);
   localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int WORK_W     = DIV_CYCLES * STEP_BITS;
   localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int ADDR_W     = $clog2(VALUE_BITS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_MINUS = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [WORK_W-1:0]   work_ff, work_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]    rsp_symbol_ff, rsp_symbol_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [DIGIT_W-1:0]  digit_mem [VALUE_BITS];
   logic [DIGIT_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_en;
   logic                mem_we;

   logic [WORK_W-1:0]   w_next;
   logic [DIGIT_W-1:0]  r_next;
   logic [RADIX_W-1:0]  trial;
   logic [RADIX_W-1:0]  diff;
   logic                slot_free;
   logic                last_step;

   // One divider cycle: STEP_BITS restoring steps on a narrow remainder.
   always_comb begin
      r_next = rem_ff;
      w_next = work_ff;
      trial  = '0;
      diff   = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial  = RADIX_W'({r_next, w_next[WORK_W-1]});
         w_next = {w_next[WORK_W-2:0], 1'b0};
         if (trial >= cfg.radix) begin
            diff      = trial - cfg.radix;
            r_next    = diff[DIGIT_W-1:0];
            w_next[0] = 1'b1;
         end else begin
            r_next = trial[DIGIT_W-1:0];
         end
      end
   end

   assign last_step = (step_ff == STEP_W'(DIV_CYCLES - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign mem_we    = (state_ff == ST_DIV) && last_step;

   // Sequencer for division and symbol output.
   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      neg_in        = neg_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'(count_ff - CNT_W'(2));
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               neg_in   = q_data[VALUE_BITS];
               work_in  = WORK_W'(q_data[VALUE_BITS-1:0]);
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = w_next;
            rem_in  = r_next;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               rem_in   = '0;
               step_in  = '0;
               count_in = count_ff + CNT_W'(1);
               if (w_next == '0) begin
                  state_in = neg_ff ? ST_MINUS : ST_READ;
               end
            end
         end
         ST_MINUS: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = SYM_MINUS;
               rsp_last_in   = 1'b0;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            // Fetch the most significant digit.
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(count_ff - CNT_W'(1));
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = symbol_of(cfg.symbols, DIGIT_IDX_W'(rd_data_ff));
               rsp_last_in   = (count_ff == CNT_W'(1));
               count_in      = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  // Fetch the next digit while this symbol goes out.
                  rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Digit buffer, least significant digit at address zero.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[count_ff[ADDR_W-1:0]] <= r_next;
      end
      if (rd_en) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   // The digit count never exceeds the buffer depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VALUE_BITS))
      else $error("digit count past buffer depth");

   // The running remainder stays below the radix during division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (RADIX_W'(rem_ff) < cfg.radix))
      else $error("remainder not below radix");

   // Emitting the final digit ends the item with a last symbol on the output.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free && count_ff == CNT_W'(1)) |=>
      (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final symbol not marked last");

   // Symbol output only happens with at least one digit left.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_READ) |-> (count_ff != '0))
      else $error("emitting with no digits");

endmodule

// ===== rtl/core/signed_integer_to_radix_digits.sv =====
// Top level of the signed integer to radix digits block: register port and wiring.
// Depends on sitrd_pkg, sitrd_front, sitrd_queue and sitrd_back.
//
// Usage: each req_ transfer carries a signed value; the block answers with its text
// in the configured radix as rsp_ transfers of one symbol byte each, most significant
// first, a leading '-' for negative values, and rsp_last on the final symbol.
// Registers (radix, symbols_low, symbols_high) are written through csr_write,
// csr_index and csr_wdata; the user must write them only while the block is idle,
// which the block does not enforce. With a bad alphabet an item is taken and dropped.
// The front classifies in the transfer cycle and writes a two-entry queue. The back
// end takes an item from the queue when it is idle, then runs a shared divider that
// retires 8 dividend bits a cycle for each digit. After that come the sign symbol
// (if any), one digit fetch from the buffer memory, then one symbol per cycle while
// the receiver is ready.
// Reset clears the registers to zero (no valid alphabet), the queue and the
// sequencer. When the receiver stalls, the symbol waits in the output register and
// the sequencer holds at its next symbol; the queue keeps taking items until it is full.
module signed_integer_to_radix_digits #(
   parameter int MAX_RADIX  = sitrd_pkg::DEF_MAX_RADIX,
   parameter int VALUE_BITS = sitrd_pkg::DEF_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [sitrd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sitrd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sitrd_pkg::VALUE_W-1:0]       req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sitrd_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                                rsp_last
);
   import sitrd_pkg::*;

   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [CSR_DATA_W-1:0] sym_low_ff, sym_low_in;
   logic [CSR_DATA_W-1:0] sym_high_ff, sym_high_in;
   cfg_type               cfg;

   logic                  push_valid;
   logic                  push_ready;
   logic [VALUE_BITS:0]   push_data;
   logic                  q_valid;
   logic                  q_pop;
   logic [VALUE_BITS:0]   q_data;

   // Register writes; an unknown index is ignored.
   always_comb begin
      radix_in    = radix_ff;
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RADIX:        radix_in    = csr_wdata[RADIX_W-1:0];
            CSR_SYMBOLS_LOW:  sym_low_in  = csr_wdata;
            CSR_SYMBOLS_HIGH: sym_high_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= '0;
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
      end else begin
         radix_ff    <= radix_in;
         sym_low_ff  <= sym_low_in;
         sym_high_ff <= sym_high_in;
      end
   end

   assign cfg.radix   = radix_ff;
   assign cfg.symbols = {sym_high_ff, sym_low_ff};

   sitrd_front #(
      .MAX_RADIX  (MAX_RADIX),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sitrd_queue #(
      .WIDTH (VALUE_BITS + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   sitrd_back #(
      .MAX_RADIX  (MAX_RADIX),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule
